### hw/rtl/assert_macros.svh
// assertion macros shared by the classifier rtl
// no dependencies; compiled away when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// clocked property, masked while reset is low
`define CLHC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// clocked property that must also hold through reset
`define CLHC_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define CLHC_ASSERT(lbl, clk, rst_n, prop, msg)
`define CLHC_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

### hw/rtl/clhc_pkg.sv
// shared types and constants of the chunk lod / horizon classifier
// no dependencies; imported by every module of the block
package clhc_pkg;

  // stage control handed to the arithmetic pipes
  typedef struct packed {
    logic en;
    logic vld;
  } stage_ctl_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    CfgTarget   = 3'd0,
    CfgMerge    = 3'd1,
    CfgGrid     = 3'd2,
    CfgDepth    = 3'd3,
    CfgOccluder = 3'd4,
    CfgPpr      = 3'd5
  } cfg_reg_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned InDataW  = 312;
  localparam int unsigned OutDataW = 72;

  localparam int unsigned FracBits = 16;
  localparam int unsigned DmW      = 49;
  localparam int unsigned IncShift = 2 * FracBits - 14;
  localparam int unsigned IncNumW  = DmW + IncShift;

  // reset values of the registers
  localparam logic [30:0] TargetRst = 31'd393216;
  localparam logic [16:0] MergeRst  = 17'd32768;
  localparam logic [10:0] GridRst   = 11'd64;
  localparam logic [4:0]  DepthRst  = 5'd16;
  localparam logic [30:0] OccRst    = 31'd0;
  localparam logic [30:0] PprRst    = 31'd65536000;

  // clamps
  localparam logic [30:0] ThrFloor  = 31'd1 << (FracBits - 2);
  localparam logic [16:0] MergeMin  = 17'd3277;
  localparam logic [16:0] MergeMax  = 17'd65536;
  localparam logic [31:0] HalfScale = 32'd1 << (FracBits - 1);
  localparam logic [40:0] ClrQMax   = 41'd1 << 40;
  localparam logic signed [42:0] ClrMaxS = 43'sd2147483647;
  localparam logic signed [42:0] ClrMinS = -43'sd2147483648;
  localparam logic [31:0] ClrMax32  = 32'h7FFF_FFFF;
  localparam logic [31:0] ClrMin32  = 32'h8000_0000;

  // result word bit positions
  localparam int unsigned SplitBit   = 64;
  localparam int unsigned MergeBit   = 65;
  localparam int unsigned BehindBit  = 66;
  localparam int unsigned ReclaimBit = 67;

endpackage

### hw/rtl/clhc_sqrt_pipe.sv
// pipelined floor square root, one root bit per stage, side word carried along
// depends on clhc_pkg
module clhc_sqrt_pipe #(
  parameter int unsigned OUT_W  = 34,
  parameter int unsigned SIDE_W = 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  clhc_pkg::stage_ctl_t   ctl_i,
  input  logic [2*OUT_W-1:0]     rad_i,
  input  logic [SIDE_W-1:0]      side_i,
  output logic                   vld_o,
  output logic [OUT_W-1:0]       root_o,
  output logic [SIDE_W-1:0]      side_o
);
  import clhc_pkg::*;

  localparam int unsigned InW = 2 * OUT_W;

  logic [InW-1:0]    rem_q  [OUT_W+1];
  logic [OUT_W-1:0]  root_q [OUT_W+1];
  logic [SIDE_W-1:0] side_q [OUT_W+1];
  logic [OUT_W:0]    vld_q;

  logic [InW:0]      trial  [OUT_W];
  logic [OUT_W-1:0]  take;
  logic [InW-1:0]    rem_d  [OUT_W];
  logic [OUT_W-1:0]  root_d [OUT_W];

  // stage k settles root bit OUT_W-1-k against the running remainder
  always_comb begin
    for (int k = 0; k < OUT_W; k++) begin
      trial[k]  = ((InW+1)'(root_q[k]) << (OUT_W - k))
                + ((InW+1)'(1) << (2 * (OUT_W - 1 - k)));
      take[k]   = trial[k] <= {1'b0, rem_q[k]};
      rem_d[k]  = take[k] ? InW'({1'b0, rem_q[k]} - trial[k]) : rem_q[k];
      root_d[k] = take[k] ? (root_q[k] | (OUT_W'(1) << (OUT_W - 1 - k))) : root_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      rem_q[0]  <= rad_i;
      root_q[0] <= '0;
      side_q[0] <= side_i;
      for (int k = 0; k < OUT_W; k++) begin
        rem_q[k+1]  <= rem_d[k];
        root_q[k+1] <= root_d[k];
        side_q[k+1] <= side_q[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (ctl_i.en) begin
      vld_q <= {vld_q[OUT_W-1:0], ctl_i.vld};
    end
  end

  assign vld_o  = vld_q[OUT_W];
  assign root_o = root_q[OUT_W];
  assign side_o = side_q[OUT_W];

endmodule

### hw/rtl/clhc_div_pipe.sv
// pipelined floor division, one quotient bit per stage, saturating quotient
// depends on clhc_pkg
module clhc_div_pipe #(
  parameter int unsigned N_W    = 65,
  parameter int unsigned D_W    = 34,
  parameter int unsigned Q_W    = 64,
  parameter int unsigned SIDE_W = 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  clhc_pkg::stage_ctl_t ctl_i,
  input  logic [N_W-1:0]       num_i,
  input  logic [D_W-1:0]       den_i,
  input  logic [SIDE_W-1:0]    side_i,
  output logic                 vld_o,
  output logic [Q_W-1:0]       quo_o,
  output logic [SIDE_W-1:0]    side_o
);
  import clhc_pkg::*;

  localparam int unsigned HiW  = N_W - Q_W;
  localparam int unsigned CmpW = (HiW > D_W) ? HiW : D_W;

  // lq holds the unused dividend bits on top and the quotient bits below
  logic [D_W-1:0]    rem_q  [Q_W+1];
  logic [Q_W-1:0]    lq_q   [Q_W+1];
  logic [D_W-1:0]    den_q  [Q_W+1];
  logic [SIDE_W-1:0] side_q [Q_W+1];
  logic [Q_W:0]      sat_q;
  logic [Q_W:0]      vld_q;

  logic              sat_c;
  logic [D_W:0]      trial [Q_W];
  logic [Q_W-1:0]    ge;
  logic [D_W-1:0]    rem_d [Q_W];
  logic [Q_W-1:0]    lq_d  [Q_W];

  // quotient would not fit, or divide by zero
  assign sat_c = CmpW'(num_i[N_W-1:Q_W]) >= CmpW'(den_i);

  always_comb begin
    for (int k = 0; k < Q_W; k++) begin
      trial[k] = {rem_q[k], lq_q[k][Q_W-1]};
      ge[k]    = trial[k] >= {1'b0, den_q[k]};
      rem_d[k] = ge[k] ? D_W'(trial[k] - {1'b0, den_q[k]}) : trial[k][D_W-1:0];
      lq_d[k]  = {lq_q[k][Q_W-2:0], ge[k]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      rem_q[0]  <= D_W'(num_i[N_W-1:Q_W]);
      lq_q[0]   <= num_i[Q_W-1:0];
      den_q[0]  <= den_i;
      side_q[0] <= side_i;
      sat_q     <= {sat_q[Q_W-1:0], sat_c};
      for (int k = 0; k < Q_W; k++) begin
        rem_q[k+1]  <= rem_d[k];
        lq_q[k+1]   <= lq_d[k];
        den_q[k+1]  <= den_q[k];
        side_q[k+1] <= side_q[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (ctl_i.en) begin
      vld_q <= {vld_q[Q_W-1:0], ctl_i.vld};
    end
  end

  assign vld_o  = vld_q[Q_W];
  assign quo_o  = sat_q[Q_W] ? '1 : lq_q[Q_W];
  assign side_o = side_q[Q_W];

endmodule

### hw/rtl/chunk_lod_horizon_classifier.sv
// Terrain chunk lod and horizon classifier. One chunk word is taken per clock while the
// pipe is not held, and one result word comes out per chunk, in order. The pipe is a
// chain of bit-per-stage units: the two 34-bit distance roots, the three 64-bit quotient
// dividers that run side by side and the 32-bit incidence root, plus six plain stages.
// The whole pipe advances together: when the result register is full and not taken,
// every stage holds and s_axis_tready drops. Registers are written on the config
// channel, which is always ready; write them only while no chunk is in flight.
// Depends on clhc_pkg, clhc_sqrt_pipe, clhc_div_pipe and assert_macros.svh.
`include "assert_macros.svh"
module chunk_lod_horizon_classifier (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // register write channel
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [clhc_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [clhc_pkg::CfgDataW-1:0]    cfg_data_i,
  // chunk words
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // eye_x, eye_y, eye_z, bound_x, bound_y, bound_z, bound_radius, chunk_width,
  // normal_x, normal_y, normal_z, tree_level, zero pad
  input  logic [clhc_pkg::InDataW-1:0]     s_axis_tdata,
  // result words
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // triangle_pixels, clearance, split_wanted, merge_wanted, behind_horizon,
  // reclaim_wanted, zero pad
  output logic [clhc_pkg::OutDataW-1:0]    m_axis_tdata
);
  import clhc_pkg::*;

  // ---------------------------------------------------------------- registers
  logic [30:0] target_q, occ_q, ppr_q;
  logic [16:0] merge_q;
  logic [10:0] grid_q;
  logic [4:0]  depth_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= TargetRst;
      merge_q  <= MergeRst;
      grid_q   <= GridRst;
      depth_q  <= DepthRst;
      occ_q    <= OccRst;
      ppr_q    <= PprRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CfgTarget:   target_q <= cfg_data_i[30:0];
        CfgMerge:    merge_q  <= cfg_data_i[16:0];
        CfgGrid:     grid_q   <= cfg_data_i[10:0];
        CfgDepth:    depth_q  <= cfg_data_i[4:0];
        CfgOccluder: occ_q    <= cfg_data_i[30:0];
        CfgPpr:      ppr_q    <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  // thresholds derived from the registers; split floored at a quarter pixel
  logic [30:0] thr_c;
  logic [16:0] frac_c;
  logic [10:0] res_c;
  logic [47:0] mthr_full_c;
  logic [31:0] mthr_q;

  always_comb begin
    thr_c = (target_q < ThrFloor) ? ThrFloor : target_q;
    if (merge_q < MergeMin) begin
      frac_c = MergeMin;
    end else if (merge_q > MergeMax) begin
      frac_c = MergeMax;
    end else begin
      frac_c = merge_q;
    end
    res_c       = (grid_q == '0) ? 11'd1 : grid_q;
    mthr_full_c = 48'(thr_c) * 48'(frac_c);
  end

  always_ff @(posedge clk_i) begin
    mthr_q <= mthr_full_c[47:16];
  end

  // ---------------------------------------------------------------- flow control
  logic en;
  logic out_vld_q;

  // every stage moves together unless a finished word is waiting
  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = out_vld_q;

  // ---------------------------------------------------------------- stage 1: input
  logic               v1_q;
  logic signed [31:0] eye1_q [3];
  logic signed [31:0] bnd1_q [3];
  logic signed [15:0] nrm1_q [3];
  logic [30:0]        br1_q, cw1_q;
  logic [4:0]         lvl1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        eye1_q[i] <= s_axis_tdata[32*i +: 32];
        bnd1_q[i] <= s_axis_tdata[96 + 32*i +: 32];
        nrm1_q[i] <= s_axis_tdata[254 + 16*i +: 16];
      end
      br1_q  <= s_axis_tdata[222:192];
      cw1_q  <= s_axis_tdata[253:223];
      lvl1_q <= s_axis_tdata[306:302];
    end
  end

  // ---------------------------------------------------------------- stage 2: products
  logic signed [32:0] d_c     [3];
  logic signed [65:0] dsq_c   [3];
  logic signed [63:0] esq_c   [3];
  logic signed [63:0] eb_c    [3];
  logic signed [48:0] dn_c    [3];
  logic [61:0]        occ2_c, num_c;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_c[i]   = {bnd1_q[i][31], bnd1_q[i]} - {eye1_q[i][31], eye1_q[i]};
      dsq_c[i] = d_c[i] * d_c[i];
      esq_c[i] = eye1_q[i] * eye1_q[i];
      eb_c[i]  = eye1_q[i] * bnd1_q[i];
      dn_c[i]  = d_c[i] * nrm1_q[i];
    end
    occ2_c = 62'(occ_q) * 62'(occ_q);
    num_c  = 62'(cw1_q) * 62'(ppr_q);
  end

  logic               v2_q;
  logic [64:0]        dsq2_q [3];
  logic [62:0]        esq2_q [3];
  logic signed [63:0] eb2_q  [3];
  logic signed [48:0] dn2_q  [3];
  logic [61:0]        occ22_q, num2_q;
  logic [30:0]        br2_q;
  logic [4:0]         lvl2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dsq2_q[i] <= dsq_c[i][64:0];
        esq2_q[i] <= esq_c[i][62:0];
        eb2_q[i]  <= eb_c[i];
        dn2_q[i]  <= dn_c[i];
      end
      occ22_q <= occ2_c;
      num2_q  <= num_c;
      br2_q   <= br1_q;
      lvl2_q  <= lvl1_q;
    end
  end

  // ---------------------------------------------------------------- stage 3: sums
  logic [66:0]        dsq_sum_c;
  logic [63:0]        e2_sum_c;
  logic signed [65:0] ebm_c;
  logic signed [49:0] dns_c;

  always_comb begin
    dsq_sum_c = 67'(dsq2_q[0]) + 67'(dsq2_q[1]) + 67'(dsq2_q[2]);
    e2_sum_c  = 64'(esq2_q[0]) + 64'(esq2_q[1]) + 64'(esq2_q[2]);
    // eye . bound minus occluder radius squared, signed
    ebm_c = {{2{eb2_q[0][63]}}, eb2_q[0]} + {{2{eb2_q[1][63]}}, eb2_q[1]}
          + {{2{eb2_q[2][63]}}, eb2_q[2]} - {4'b0, occ22_q};
    dns_c = {dn2_q[0][48], dn2_q[0]} + {dn2_q[1][48], dn2_q[1]}
          + {dn2_q[2][48], dn2_q[2]};
  end

  logic               v3_q;
  logic [66:0]        dsq3_q;
  logic [63:0]        e23_q;
  logic signed [65:0] ebm3_q;
  logic signed [49:0] dns3_q;
  logic               under3_q;
  logic [61:0]        num3_q;
  logic [30:0]        br3_q;
  logic [4:0]         lvl3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      dsq3_q   <= dsq_sum_c;
      e23_q    <= e2_sum_c;
      ebm3_q   <= ebm_c;
      dns3_q   <= dns_c;
      under3_q <= e2_sum_c <= 64'(occ22_q);
      num3_q   <= num2_q;
      br3_q    <= br2_q;
      lvl3_q   <= lvl2_q;
    end
  end

  // ---------------------------------------------------------------- distance roots
  logic [33:0]  root_d, root_e;
  logic         vld_rd, vld_re;
  logic [147:0] side_rd;
  logic [66:0]  side_re;

  clhc_sqrt_pipe #(.OUT_W(34), .SIDE_W(148)) u_sqrt_dist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  ('{en: en, vld: v3_q}),
    .rad_i  ({1'b0, dsq3_q}),
    .side_i ({num3_q, dns3_q, br3_q, lvl3_q}),
    .vld_o  (vld_rd),
    .root_o (root_d),
    .side_o (side_rd)
  );

  clhc_sqrt_pipe #(.OUT_W(34), .SIDE_W(67)) u_sqrt_eye (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  ('{en: en, vld: v3_q}),
    .rad_i  ({4'b0, e23_q}),
    .side_i ({ebm3_q, under3_q}),
    .vld_o  (vld_re),
    .root_o (root_e),
    .side_o (side_re)
  );

  // ---------------------------------------------------------------- stage 4: operands
  logic [61:0]        num_r;
  logic signed [49:0] dns_r;
  logic [30:0]        br_r;
  logic [4:0]         lvl_r;
  logic signed [65:0] ebm_r;
  logic               under_r;
  logic               inside_c;
  logic [33:0]        gap_c;
  logic [44:0]        den_c;
  logic signed [49:0] dns_neg_c;
  logic signed [65:0] ebm_neg_c;
  logic [48:0]        dm_c;
  logic [64:0]        cmag_c;

  assign {num_r, dns_r, br_r, lvl_r} = side_rd;
  assign {ebm_r, under_r}            = side_re;

  always_comb begin
    // observer inside the bounding sphere
    inside_c  = root_d <= {3'b0, br_r};
    gap_c     = root_d - {3'b0, br_r};
    den_c     = 45'(res_c) * 45'(gap_c);
    dns_neg_c = -dns_r;
    dm_c      = dns_r[49] ? dns_neg_c[48:0] : dns_r[48:0];
    ebm_neg_c = -ebm_r;
    cmag_c    = ebm_r[65] ? ebm_neg_c[64:0] : ebm_r[64:0];
  end

  logic        v4_q;
  logic [61:0] num4_q;
  logic [44:0] den4_q;
  logic [48:0] dm4_q;
  logic [33:0] dist4_q, ed4_q;
  logic [64:0] cmag4_q;
  logic        neg4_q, under4_q, inside4_q;
  logic [30:0] br4_q;
  logic [4:0]  lvl4_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      num4_q    <= num_r;
      den4_q    <= den_c;
      dm4_q     <= dm_c;
      dist4_q   <= root_d;
      ed4_q     <= root_e;
      cmag4_q   <= cmag_c;
      neg4_q    <= ebm_r[65];
      under4_q  <= under_r;
      inside4_q <= inside_c;
      br4_q     <= br_r;
      lvl4_q    <= lvl_r;
    end
  end

  // ---------------------------------------------------------------- dividers
  // base width per pixel, incidence ratio and horizon distance run side by side
  logic [63:0] q_base, q_inc, q_clr;
  logic        vld_d1, vld_d2, vld_d3;
  logic        inside_r;
  logic [4:0]  lvl_s;
  logic [32:0] side_d3;
  logic        neg_s, under_s;
  logic [30:0] br_s;

  clhc_div_pipe #(.N_W(65), .D_W(45), .Q_W(64), .SIDE_W(1)) u_div_base (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  ('{en: en, vld: v4_q}),
    .num_i  ({3'b0, num4_q}),
    .den_i  (den4_q),
    .side_i (inside4_q),
    .vld_o  (vld_d1),
    .quo_o  (q_base),
    .side_o (inside_r)
  );

  clhc_div_pipe #(.N_W(IncNumW), .D_W(34), .Q_W(64), .SIDE_W(5)) u_div_inc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  ('{en: en, vld: v4_q}),
    .num_i  ({dm4_q, {IncShift{1'b0}}}),
    .den_i  (dist4_q),
    .side_i (lvl4_q),
    .vld_o  (vld_d2),
    .quo_o  (q_inc),
    .side_o (lvl_s)
  );

  clhc_div_pipe #(.N_W(65), .D_W(34), .Q_W(64), .SIDE_W(33)) u_div_clr (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  ('{en: en, vld: v4_q}),
    .num_i  (cmag4_q),
    .den_i  (ed4_q),
    .side_i ({neg4_q, under4_q, br4_q}),
    .vld_o  (vld_d3),
    .quo_o  (q_clr),
    .side_o (side_d3)
  );

  assign {neg_s, under_s, br_s} = side_d3;

  // ---------------------------------------------------------------- clearance
  logic [40:0]        qc_c;
  logic signed [42:0] qs_c, brs_c, clr_w_c;
  logic [31:0]        clr_c;
  logic               behind_c, reclaim_c;
  logic               qsat_c;

  always_comb begin
    qc_c    = (q_clr > 64'(ClrQMax)) ? ClrQMax : q_clr[40:0];
    qs_c    = $signed({2'b00, qc_c});
    brs_c   = $signed({12'b0, br_s});
    clr_w_c = (neg_s ? -qs_c : qs_c) + brs_c;
    if (under_s) begin
      // observer below the occluder surface
      clr_c     = ClrMax32;
      behind_c  = 1'b0;
      reclaim_c = 1'b0;
    end else begin
      behind_c  = clr_w_c[42];
      reclaim_c = clr_w_c < -brs_c;
      if (clr_w_c > ClrMaxS) begin
        clr_c = ClrMax32;
      end else if (clr_w_c < ClrMinS) begin
        clr_c = ClrMin32;
      end else begin
        clr_c = clr_w_c[31:0];
      end
    end
    // base width this large saturates the pixel count whatever the incidence
    qsat_c = |q_base[63:33];
  end

  // ---------------------------------------------------------------- incidence root
  logic [31:0] root_i;
  logic        vld_ri;
  logic [73:0] side_ri;

  clhc_sqrt_pipe #(.OUT_W(32), .SIDE_W(74)) u_sqrt_inc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  ('{en: en, vld: vld_d2}),
    .rad_i  (q_inc),
    .side_i ({clr_c, behind_c, reclaim_c, inside_r, lvl_s, qsat_c, q_base[32:0]}),
    .vld_o  (vld_ri),
    .root_o (root_i),
    .side_o (side_ri)
  );

  logic [31:0] clr_r;
  logic        behind_r, reclaim_r, inside_i, qsat_r;
  logic [4:0]  lvl_i;
  logic [32:0] qn_r;
  logic [31:0] s_c;

  assign {clr_r, behind_r, reclaim_r, inside_i, lvl_i, qsat_r, qn_r} = side_ri;
  // incidence factor never below one half
  assign s_c = (root_i < HalfScale) ? HalfScale : root_i;

  // ---------------------------------------------------------------- stage 6: scale
  logic        v6_q;
  logic [64:0] prod6_q;
  logic [31:0] clr6_q;
  logic        behind6_q, reclaim6_q, inside6_q, qsat6_q;
  logic [4:0]  lvl6_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod6_q    <= 65'(qn_r) * 65'(s_c);
      clr6_q     <= clr_r;
      behind6_q  <= behind_r;
      reclaim6_q <= reclaim_r;
      inside6_q  <= inside_i;
      qsat6_q    <= qsat_r;
      lvl6_q     <= lvl_i;
    end
  end

  // ---------------------------------------------------------------- stage 7: result word
  logic [31:0] pix_c;
  logic        split_c, merge_c;

  always_comb begin
    pix_c   = (inside6_q || qsat6_q || (|prod6_q[64:48])) ? '1 : prod6_q[47:16];
    split_c = (lvl6_q < depth_q) && (pix_c > {1'b0, thr_c});
    merge_c = pix_c < mthr_q;
  end

  logic [OutDataW-1:0] out_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= {4'b0, reclaim6_q, behind6_q, merge_c, split_c, clr6_q, pix_c};
    end
  end

  assign m_axis_tdata = out_q;

  // ---------------------------------------------------------------- valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
      v4_q      <= 1'b0;
      v6_q      <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      v1_q      <= s_axis_tvalid;
      v2_q      <= v1_q;
      v3_q      <= v2_q;
      v4_q      <= vld_rd;
      v6_q      <= vld_ri;
      out_vld_q <= v6_q;
    end
  end

  // ---------------------------------------------------------------- checks
  `CLHC_ASSERT_NR(a_roots_in_step, clk_i, vld_rd == vld_re, "distance roots out of step")
  `CLHC_ASSERT_NR(a_divs_in_step, clk_i, (vld_d1 == vld_d2) && (vld_d3 == vld_d2), "dividers out of step")
  `CLHC_ASSERT(a_reclaim_behind, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[ReclaimBit] |-> m_axis_tdata[BehindBit], "reclaim without behind")
  `CLHC_ASSERT(a_behind_sign, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[BehindBit] |-> m_axis_tdata[63], "behind with positive clearance")
  `CLHC_ASSERT(a_sat_no_merge, clk_i, rst_ni, m_axis_tvalid && (m_axis_tdata[31:0] == '1) |-> !m_axis_tdata[MergeBit], "merge on saturated width")

endmodule
